@@ sv/matrix_vector_multiply_accumulate_unit_defines.svh @@
// Assertion macros shared by the matrix-vector multiply-accumulate RTL.
// No dependencies; define SYNTH to drop the checks from a build.
`ifndef MATRIX_VECTOR_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define MVMA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Checked on every clock edge, reset included.
`define MVMA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define MVMA_ASSERT(lbl, clk, rst_n, prop)
`define MVMA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ sv/mvma_pkg.sv @@
// Types and constants for the matrix-vector multiply-accumulate unit.
// No dependencies.
package mvma_pkg;

  localparam int LANES   = 8;
  localparam int LANE_SH = 3;            // log2(LANES)
  localparam int ELEM_W  = 16;           // Q8.8
  localparam int PROD_W  = 2 * ELEM_W;   // Q16.16
  localparam int DOT_W   = PROD_W + LANE_SH;
  localparam int ACC_W   = 48;           // Q32.16
  localparam int ROW_W   = 12;
  localparam int CHUNK_W = 5;
  localparam int CFG_W   = 9;

  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 9'd8;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic OP_LOAD_VECTOR = 1'b0;
  localparam logic OP_MATRIX_ROW  = 1'b1;

  typedef logic [LANES-1:0][ELEM_W-1:0] lane_vec_t;

  typedef struct packed {
    logic                     op;
    logic [ROW_W-1:0]         row_index;
    logic [CHUNK_W-1:0]       chunk_index;
    logic signed [ELEM_W-1:0] value_7;
    logic signed [ELEM_W-1:0] value_6;
    logic signed [ELEM_W-1:0] value_5;
    logic signed [ELEM_W-1:0] value_4;
    logic signed [ELEM_W-1:0] value_3;
    logic signed [ELEM_W-1:0] value_2;
    logic signed [ELEM_W-1:0] value_1;
    logic signed [ELEM_W-1:0] value_0;
    logic signed [ACC_W-1:0]  acc_in;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic signed [ACC_W-1:0] row_sum;
  } out_item_t;

  typedef struct packed {
    logic             mul_en;
    logic             sum_en;
    logic [LANES-1:0] lane_mask;
  } dot_ctrl_t;

endpackage

@@ sv/mvma_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mvma_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mvma_dot.sv @@
// Eight-lane dot product: masked lane products, then a registered adder tree.
// Depends on mvma_pkg.
module mvma_dot (
  input  logic                                clk,
  input  mvma_pkg::dot_ctrl_t                 ctrl,
  input  mvma_pkg::lane_vec_t                 vec_lanes,
  input  mvma_pkg::lane_vec_t                 mat_lanes,
  output logic signed [mvma_pkg::DOT_W-1:0]   dot
);

  localparam int N = mvma_pkg::LANES;

  logic signed [mvma_pkg::PROD_W-1:0] prod_r   [N];
  logic signed [mvma_pkg::PROD_W-1:0] prod_nxt [N];
  logic signed [mvma_pkg::PROD_W-1:0] mult     [N];
  logic signed [mvma_pkg::DOT_W-1:0]  lvl1 [N/2];
  logic signed [mvma_pkg::DOT_W-1:0]  lvl2 [N/4];
  logic signed [mvma_pkg::DOT_W-1:0]  dot_r;
  logic signed [mvma_pkg::DOT_W-1:0]  dot_nxt;

  // Masked lanes contribute zero.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      mult[i]     = $signed(mat_lanes[i]) * $signed(vec_lanes[i]);
      prod_nxt[i] = ctrl.lane_mask[i] ? mult[i] : '0;
    end
  end

  always_comb begin
    for (int j = 0; j < N/2; j++) begin
      lvl1[j] = mvma_pkg::DOT_W'(prod_r[2*j]) + mvma_pkg::DOT_W'(prod_r[2*j+1]);
    end
    for (int j = 0; j < N/4; j++) begin
      lvl2[j] = lvl1[2*j] + lvl1[2*j+1];
    end
    dot_nxt = lvl2[0] + lvl2[1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      for (int i = 0; i < N; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (ctrl.sum_en) begin
      dot_r <= dot_nxt;
    end
  end

  assign dot = dot_r;

endmodule

@@ sv/matrix_vector_multiply_accumulate_unit.sv @@
// Matrix-vector multiply-accumulate unit (GEMV), Q8.8 elements, Q32.16 sums.
// Depends on mvma_pkg, mvma_ram, mvma_dot and the assertion macro header.
//
// Usage: load vector b chunk by chunk with op=0 transactions (8 elements each,
// stored whole into the vector RAM at slot chunk_index modulo the RAM depth).
// Then stream each matrix row as op=1 transactions, one 8-element chunk per
// transaction. Chunk 0 of a row seeds the accumulator from acc_in; every chunk
// adds the dot product of its lanes with the stored b chunk, lanes whose column
// is at or past column_count contributing nothing, and saturates to 48 bits.
// The chunk (column_count-1)/8 closes the row and emits {out_row, row_sum}.
// Timing: a vector load leaves the unit idle and the next transaction may follow
// immediately. A matrix chunk occupies the unit from accept until S_ACC ends
// (accept with the vector RAM read, lane multiply, adder tree, then accumulate),
// so no new transaction is accepted until it is done; the RAM read latency and
// the registered multiply and tree stages set this. A finished result sits in
// the output register while the next transaction is taken; the unit only stalls
// if a second row completes before the first one has been taken. The user must
// write column_count through cfg_we/cfg_wdata only while the unit is idle; the
// unit does not enforce this. Values above MAX_COLUMNS act as MAX_COLUMNS.
// MAX_COLUMNS must be a power of two multiple of 8. The vector RAM has no reset;
// reading a chunk never loaded gives undefined lanes.
`include "matrix_vector_multiply_accumulate_unit_defines.svh"

module matrix_vector_multiply_accumulate_unit #(
  parameter int MAX_COLUMNS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mvma_pkg::in_item_t               in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output mvma_pkg::out_item_t              out_data,
  // configuration
  input  logic                             cfg_we,
  input  logic [mvma_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int DEPTH  = MAX_COLUMNS / mvma_pkg::LANES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int EW     = (CNT_W > mvma_pkg::CFG_W) ? CNT_W : mvma_pkg::CFG_W;
  localparam int VEC_W  = mvma_pkg::LANES * mvma_pkg::ELEM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_ACC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration register.
  logic [mvma_pkg::CFG_W-1:0] column_count_r;

  // Held matrix transaction.
  mvma_pkg::in_item_t            item_r;
  logic [mvma_pkg::LANES-1:0]    mask_r, mask_nxt;
  logic                          last_r, last_nxt;
  logic                          first_r;

  // Accumulator and output register.
  logic signed [mvma_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                              out_valid_r, out_valid_nxt;
  mvma_pkg::out_item_t               out_data_r;

  logic                              in_fire;
  logic                              acc_done;
  logic [AW-1:0]                     slot;
  logic                              ram_we, ram_re;
  logic [VEC_W-1:0]                  ram_rdata;
  logic [EW-1:0]                     eff_count;
  logic [EW-1:0]                     last_chunk;
  logic [EW-1:0]                     col;
  mvma_pkg::dot_ctrl_t               dot_ctrl;
  mvma_pkg::lane_vec_t               vec_lanes, mat_lanes, load_lanes;
  logic signed [mvma_pkg::DOT_W-1:0] dot;
  logic signed [mvma_pkg::ACC_W-1:0] acc_base;
  logic signed [mvma_pkg::ACC_W:0]   sum_ext;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Chunk index wraps modulo the RAM depth (power of two).
  assign slot = AW'(in_data.chunk_index) & AW'(DEPTH - 1);

  assign ram_we = in_fire && (in_data.op == mvma_pkg::OP_LOAD_VECTOR);
  assign ram_re = in_fire && (in_data.op == mvma_pkg::OP_MATRIX_ROW);

  assign load_lanes = {in_data.value_7, in_data.value_6, in_data.value_5,
                       in_data.value_4, in_data.value_3, in_data.value_2,
                       in_data.value_1, in_data.value_0};

  mvma_ram #(
    .WIDTH (VEC_W),
    .DEPTH (DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (load_lanes),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // Effective column count, last chunk and lane mask, decoded at accept.
  always_comb begin
    eff_count = (EW'(column_count_r) > EW'(MAX_COLUMNS)) ? EW'(MAX_COLUMNS)
                                                        : EW'(column_count_r);
    last_chunk = (eff_count == '0) ? '0 : ((eff_count - EW'(1)) >> mvma_pkg::LANE_SH);
    last_nxt   = (EW'(in_data.chunk_index) == last_chunk);
    col        = '0;
    for (int i = 0; i < mvma_pkg::LANES; i++) begin
      col         = (EW'(in_data.chunk_index) << mvma_pkg::LANE_SH) | EW'(i);
      mask_nxt[i] = (col < eff_count);
    end
  end

  assign vec_lanes = mvma_pkg::lane_vec_t'(ram_rdata);
  assign mat_lanes = {item_r.value_7, item_r.value_6, item_r.value_5,
                      item_r.value_4, item_r.value_3, item_r.value_2,
                      item_r.value_1, item_r.value_0};

  assign dot_ctrl.mul_en    = (state_r == S_READ);
  assign dot_ctrl.sum_en    = (state_r == S_MUL);
  assign dot_ctrl.lane_mask = mask_r;

  mvma_dot u_dot (
    .clk       (clk),
    .ctrl      (dot_ctrl),
    .vec_lanes (vec_lanes),
    .mat_lanes (mat_lanes),
    .dot       (dot)
  );

  // Accumulate and saturate to 48 bits.
  always_comb begin
    acc_base = first_r ? item_r.acc_in : acc_r;
    sum_ext  = (mvma_pkg::ACC_W + 1)'(acc_base) + (mvma_pkg::ACC_W + 1)'(dot);
    if (sum_ext[mvma_pkg::ACC_W] != sum_ext[mvma_pkg::ACC_W-1]) begin
      acc_nxt = sum_ext[mvma_pkg::ACC_W] ? mvma_pkg::ACC_MIN : mvma_pkg::ACC_MAX;
    end else begin
      acc_nxt = sum_ext[mvma_pkg::ACC_W-1:0];
    end
  end

  // A closing chunk waits in S_ACC while the output register is still full.
  assign acc_done = !last_r || !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ram_re) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC: begin
        if (acc_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) ||
                         ((state_r == S_ACC) && last_r && acc_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      column_count_r <= mvma_pkg::COLUMN_COUNT_RESET;
      acc_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        column_count_r <= cfg_wdata;
      end
      if ((state_r == S_ACC) && acc_done) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      item_r  <= in_data;
      mask_r  <= mask_nxt;
      last_r  <= last_nxt;
      first_r <= (in_data.chunk_index == '0);
    end
    if ((state_r == S_ACC) && last_r && acc_done) begin
      out_data_r.out_row <= item_r.row_index;
      out_data_r.row_sum <= acc_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result only ever comes out of the accumulate step.
  `MVMA_ASSERT(a_result_from_acc, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_ACC))
  // A matrix chunk always starts with the vector RAM read.
  `MVMA_ASSERT(a_matrix_reads, clk, rst_n, ram_re |=> state_r == S_READ)
  // Vector loads never land while a matrix chunk is in flight.
  `MVMA_ASSERT(a_load_when_idle, clk, rst_n, ram_we |-> state_r == S_IDLE)
  // The accumulator moves only when a chunk completes.
  `MVMA_ASSERT(a_acc_only_in_acc, clk, rst_n,
    ($past(rst_n) && !$stable(acc_r)) |-> $past(state_r == S_ACC))
  // Read and write of the vector RAM never coincide.
  `MVMA_ASSERT_ALWAYS(a_ram_one_port, clk, !(ram_we && ram_re))

endmodule

@@ tb/tb.sv @@
// Testbench for the matrix-vector multiply-accumulate unit: directed corners, random traffic.
// Depends on mvma_pkg and matrix_vector_multiply_accumulate_unit.
// Self-checking: a row-sum predictor tracks the vector store, accumulator and column_count.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_MAX_COLUMNS = 256;
  localparam int STORE_SLOTS    = TB_MAX_COLUMNS / mvma_pkg::LANES;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  mvma_pkg::in_item_t         in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  mvma_pkg::out_item_t        out_data;
  logic                       cfg_we    = 1'b0;
  logic [mvma_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Predictor state: a copy of the vector RAM, the row accumulator and column_count.
  logic signed [mvma_pkg::ELEM_W-1:0] vec_model [STORE_SLOTS][mvma_pkg::LANES];
  logic signed [mvma_pkg::ACC_W-1:0]  acc_model = '0;
  logic [mvma_pkg::CFG_W-1:0]         cols_model = mvma_pkg::COLUMN_COUNT_RESET;

  // Row results still owed by the DUT, oldest first.
  mvma_pkg::out_item_t pending_row_sums[$];

  int err_count  = 0;
  int burst_left = 0;   // transactions left in the current sender burst
  int ready_mode = 0;   // receiver backpressure style
  int mode_left  = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  matrix_vector_multiply_accumulate_unit #(
    .MAX_COLUMNS(TB_MAX_COLUMNS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Lane access helpers. The struct keeps lanes as separate named fields.
  // ---------------------------------------------------------------------------
  function automatic logic signed [mvma_pkg::ELEM_W-1:0] lane_of(mvma_pkg::in_item_t t,
                                                                 int k);
    unique case (k)
      0: return t.value_0;
      1: return t.value_1;
      2: return t.value_2;
      3: return t.value_3;
      4: return t.value_4;
      5: return t.value_5;
      6: return t.value_6;
      default: return t.value_7;
    endcase
  endfunction

  function automatic mvma_pkg::in_item_t with_lane(mvma_pkg::in_item_t t, int k,
                                                   logic signed [mvma_pkg::ELEM_W-1:0] v);
    unique case (k)
      0: t.value_0 = v;
      1: t.value_1 = v;
      2: t.value_2 = v;
      3: t.value_3 = v;
      4: t.value_4 = v;
      5: t.value_5 = v;
      6: t.value_6 = v;
      default: t.value_7 = v;
    endcase
    return t;
  endfunction

  // Element values lean on the corners: full-scale positive, full-scale negative, 0, -1 LSB.
  function automatic logic signed [mvma_pkg::ELEM_W-1:0] rand_elem();
    unique case ($urandom_range(0, 15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return mvma_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // Starting values: rails, near the rails (so a chunk can saturate), small, or full random.
  function automatic logic signed [mvma_pkg::ACC_W-1:0] rand_acc();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    unique case ($urandom_range(0, 7))
      0: return mvma_pkg::ACC_MAX;
      1: return mvma_pkg::ACC_MIN;
      2: return mvma_pkg::ACC_MAX - mvma_pkg::ACC_W'($urandom);
      3: return mvma_pkg::ACC_MIN + mvma_pkg::ACC_W'($urandom);
      4: return mvma_pkg::ACC_W'(signed'(raw[31:0]));
      default: return raw[mvma_pkg::ACC_W-1:0];
    endcase
  endfunction

  function automatic mvma_pkg::in_item_t uniform_item(
      logic op, logic [mvma_pkg::ROW_W-1:0] row,
      logic [mvma_pkg::CHUNK_W-1:0] chunk,
      logic signed [mvma_pkg::ELEM_W-1:0] v,
      logic signed [mvma_pkg::ACC_W-1:0] acc);
    mvma_pkg::in_item_t t;
    t.op          = op;
    t.row_index   = row;
    t.chunk_index = chunk;
    t.acc_in      = acc;
    for (int k = 0; k < mvma_pkg::LANES; k++) t = with_lane(t, k, v);
    return t;
  endfunction

  function automatic mvma_pkg::in_item_t random_item(
      logic op, logic [mvma_pkg::ROW_W-1:0] row,
      logic [mvma_pkg::CHUNK_W-1:0] chunk);
    mvma_pkg::in_item_t t;
    t = uniform_item(op, row, chunk, '0, rand_acc());
    for (int k = 0; k < mvma_pkg::LANES; k++) t = with_lane(t, k, rand_elem());
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Row-sum predictor, run once per accepted transaction.
  // Loads overwrite a whole slot regardless of column_count. Matrix chunks
  // add the masked lane products, saturate to 48 bits, and report on the
  // last chunk of the row. Chunk 0 restarts from acc_in.
  // ---------------------------------------------------------------------------
  task automatic accumulate_chunk(input mvma_pkg::in_item_t t);
    int                  slot;
    int                  cnt;
    int                  last_chunk;
    longint              dot;
    longint              acc;
    mvma_pkg::out_item_t r;
    slot = int'(t.chunk_index) % STORE_SLOTS;
    if (t.op == mvma_pkg::OP_LOAD_VECTOR) begin
      for (int k = 0; k < mvma_pkg::LANES; k++) vec_model[slot][k] = lane_of(t, k);
      return;
    end
    // column_count above the RAM size behaves as the RAM size
    cnt        = (cols_model > TB_MAX_COLUMNS) ? TB_MAX_COLUMNS : int'(cols_model);
    last_chunk = (cnt == 0) ? 0 : (cnt - 1) / mvma_pkg::LANES;
    dot = 0;
    for (int k = 0; k < mvma_pkg::LANES; k++) begin
      if (int'(t.chunk_index) * mvma_pkg::LANES + k < cnt)
        dot += longint'(lane_of(t, k)) * longint'(vec_model[slot][k]);
    end
    acc = (t.chunk_index == 0) ? longint'(t.acc_in) : longint'(acc_model);
    acc += dot;
    if (acc > longint'(mvma_pkg::ACC_MAX)) acc = longint'(mvma_pkg::ACC_MAX);
    else if (acc < longint'(mvma_pkg::ACC_MIN)) acc = longint'(mvma_pkg::ACC_MIN);
    acc_model = acc[mvma_pkg::ACC_W-1:0];
    if (int'(t.chunk_index) == last_chunk) begin
      r.out_row = t.row_index;
      r.row_sum = acc_model;
      pending_row_sums.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Transactions go out in bursts of random length; a burst may be
  // preceded by an idle gap. Valid is driven on the falling edge and held
  // until a rising edge sees ready.
  // ---------------------------------------------------------------------------
  task automatic send(input mvma_pkg::in_item_t t);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    accumulate_chunk(t);
  endtask

  // Drop valid and hold off until every owed result has come back. The tail
  // covers a matrix chunk still in the pipe that produces no result.
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_row_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_column_count(input logic [mvma_pkg::CFG_W-1:0] v);
    wait_for_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cols_model = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver backpressure: the style is redrawn at random, choosing between
  // always ready, random drops, and long stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      unique case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transaction is matched against the oldest
  // owed row sum, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mvma_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_row_sums.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d sum %0d",
                 $time, out_data.out_row, out_data.row_sum);
        err_count++;
      end else begin
        want = pending_row_sums.pop_front();
        if (out_data.out_row !== want.out_row) begin
          $display("%0t: out_row mismatch, expected %0d, got %0d",
                   $time, want.out_row, out_data.out_row);
          err_count++;
        end
        if (out_data.row_sum !== want.row_sum) begin
          $display("%0t: row_sum mismatch (row %0d), expected %0d, got %0d",
                   $time, want.out_row, want.row_sum, out_data.row_sum);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset column count (8): one chunk per row. Saturation at both rails,
  // the largest product, and a chunk past the row end.
  task automatic test_directed_single_chunk();
    send(uniform_item(mvma_pkg::OP_LOAD_VECTOR, 0, 0, 16'sh7fff, '0));
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 0, 0, 16'sh7fff, mvma_pkg::ACC_MAX));
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 12'hfff, 0, 16'sh8000, mvma_pkg::ACC_MIN));
    send(uniform_item(mvma_pkg::OP_LOAD_VECTOR, 0, 0, 16'sh8000, '0));
    // -128.0 * -128.0 in every lane: largest positive product
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 1, 0, 16'sh8000, '0));
    send(random_item(mvma_pkg::OP_LOAD_VECTOR, 12'habc, 1));
    send(random_item(mvma_pkg::OP_MATRIX_ROW, 2, 1));   // fully masked, no result
    send(random_item(mvma_pkg::OP_LOAD_VECTOR, 12'h543, 0));
    send(random_item(mvma_pkg::OP_MATRIX_ROW, 3, 0));
  endtask

  // Three-chunk rows with a partly masked last chunk, saturation carried
  // across chunks, a row index change mid-row, and a chunk past the end.
  task automatic test_directed_multi_chunk();
    mvma_pkg::in_item_t t;
    write_column_count(9'd20);
    send(uniform_item(mvma_pkg::OP_LOAD_VECTOR, 0, 2, 16'sh7fff, '0));
    send(uniform_item(mvma_pkg::OP_LOAD_VECTOR, 0, 3, 16'sh0100, '0));
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 7, 0, 16'sh0000, mvma_pkg::ACC_MAX));
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 7, 1, 16'sh0000, '0));
    // lanes 4..7 are columns 20..23, past the 20 columns, and carry junk that must be masked
    t = uniform_item(mvma_pkg::OP_MATRIX_ROW, 9, 2, 16'sh7fff, '0);
    for (int k = 4; k < mvma_pkg::LANES; k++) t = with_lane(t, k, 16'sh8000);
    send(t);
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 7, 3, 16'sh0100, '0));
    for (int c = 0; c < 3; c++)
      send(random_item(mvma_pkg::OP_MATRIX_ROW, 12'd4000, mvma_pkg::CHUNK_W'(c)));
  endtask

  // column_count 0: chunk 0 closes the row and reports acc_in unchanged.
  task automatic test_column_count_zero();
    write_column_count(9'd0);
    send(uniform_item(mvma_pkg::OP_MATRIX_ROW, 5, 0, 16'sh7fff, mvma_pkg::ACC_MIN));
    send(random_item(mvma_pkg::OP_MATRIX_ROW, 6, 0));
    send(random_item(mvma_pkg::OP_MATRIX_ROW, 6, 2));
  endtask

  // Every RAM slot gets loaded before random traffic may read any of them.
  task automatic test_fill_vector_store();
    for (int s = 0; s < STORE_SLOTS; s++)
      send(random_item(mvma_pkg::OP_LOAD_VECTOR, mvma_pkg::ROW_W'($urandom),
                       mvma_pkg::CHUNK_W'(s)));
  endtask

  // Mostly complete rows with random content; the rest is vector reloads,
  // chunks past the row end, abandoned rows and full drains.
  task automatic test_random_traffic(input int cols, input int budget);
    int sent;
    int last;
    int pick;
    int row;
    int stop;
    write_column_count(mvma_pkg::CFG_W'(cols));
    last = (cols == 0) ? 0
                       : ((cols > TB_MAX_COLUMNS ? TB_MAX_COLUMNS : cols) - 1) / mvma_pkg::LANES;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      row  = $urandom_range(0, 4095);
      if (pick < 70) begin
        for (int k = 0; k <= last; k++) begin
          // b may change under a row in flight
          if ($urandom_range(0, 24) == 0) begin
            send(random_item(mvma_pkg::OP_LOAD_VECTOR, mvma_pkg::ROW_W'($urandom),
                             mvma_pkg::CHUNK_W'($urandom)));
            sent++;
          end
          if ($urandom_range(0, 19) == 0) row = $urandom_range(0, 4095);
          send(random_item(mvma_pkg::OP_MATRIX_ROW, mvma_pkg::ROW_W'(row),
                           mvma_pkg::CHUNK_W'(k)));
          sent++;
        end
      end else if (pick < 80) begin
        send(random_item(mvma_pkg::OP_LOAD_VECTOR, mvma_pkg::ROW_W'(row),
                         mvma_pkg::CHUNK_W'($urandom)));
        sent++;
      end else if (pick < 90) begin
        stop = (last < STORE_SLOTS - 1) ? $urandom_range(last + 1, STORE_SLOTS - 1)
                                        : $urandom_range(0, STORE_SLOTS - 1);
        send(random_item(mvma_pkg::OP_MATRIX_ROW, mvma_pkg::ROW_W'(row),
                         mvma_pkg::CHUNK_W'(stop)));
        sent++;
      end else if (pick < 97) begin
        // row abandoned before its last chunk
        stop = (last == 0) ? 0 : $urandom_range(0, last - 1);
        for (int k = 0; k <= stop; k++) begin
          send(random_item(mvma_pkg::OP_MATRIX_ROW, mvma_pkg::ROW_W'(row),
                           mvma_pkg::CHUNK_W'(k)));
          sent++;
        end
      end else begin
        wait_for_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_single_chunk();
    test_directed_multi_chunk();
    test_column_count_zero();
    test_fill_vector_store();

    test_random_traffic(1, 85);
    test_random_traffic(8, 85);
    test_random_traffic(256, 70);
    test_random_traffic(0, 85);
    test_random_traffic(511, 70);
    test_random_traffic($urandom_range(2, 64), 85);
    test_random_traffic($urandom_range(2, 64), 85);
    test_random_traffic($urandom_range(2, 64), 85);
    test_random_traffic($urandom_range(65, 255), 70);
    test_random_traffic(257, 70);
    test_random_traffic(9, 85);

    wait_for_idle();
    repeat (16) @(posedge clk);
    if (err_count == 0 && pending_row_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
